FILE: sv/mlet_pkg.sv
// mlet_pkg: shared widths, codes, sentinel and the command/status structs
// used between the max line envelope table controller and datapath
// no dependencies
package mlet_pkg;

    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 63;
    localparam int VAL_W   = 64;
    localparam int DEN_W   = SLOPE_W + 1;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [VAL_W-1:0] SENTINEL = 64'sh3f3f3f3f3f3f3f3f;

    typedef enum logic [1:0] {
        BP_SENT,
        BP_EQ,
        BP_DIV
    } bp_src_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_MOVE,
        WR_NEW,
        WR_BP
    } wr_kind_t;

    typedef struct packed {
        logic     ld_in;
        logic     ld_a;
        logic     ld_b;
        logic     bp_load;
        bp_src_t  bp_src;
        logic     div_start;
        wr_kind_t wr_kind;
        logic     mul;
        logic     acc_sum;
        logic     val_load;
    } dp_cmd_t;

    typedef struct packed {
        logic slope_le;
        logic slope_eq;
        logic bp_lt_x;
        logic covers_raw;
        logic div_done;
    } dp_stat_t;

endpackage

FILE: sv/mlet_div.sv
// mlet_div: radix-2 restoring divider giving the floor quotient of a
// 64-bit signed numerator by a 33-bit signed nonzero denominator
// depends on mlet_pkg
module mlet_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [mlet_pkg::VAL_W-1:0] num,
    input  logic signed [mlet_pkg::DEN_W-1:0] den,
    output logic                              done,
    output logic        [mlet_pkg::VAL_W-1:0] quo
);
    import mlet_pkg::*;

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic [VAL_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] d_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [VAL_W-1:0] n_mag;
    logic [DEN_W-1:0] d_mag;

    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[VAL_W-1]};
        diff     = rem_sh - {1'b0, d_reg};
        ge       = rem_sh >= {1'b0, d_reg};
        rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        n_mag    = num[VAL_W-1] ? (~num + 1'b1) : num;
        d_mag    = den[DEN_W-1] ? (~den + 1'b1) : den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            d_reg    <= '0;
            neg_reg  <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(VAL_W);
            q_reg    <= n_mag;
            rem_reg  <= '0;
            d_reg    <= d_mag;
            neg_reg  <= num[VAL_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[VAL_W-2:0], ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // truncated quotient, stepped down by one when inexact and negative
    assign quo  = !neg_reg ? q_reg : ((rem_reg != '0) ? ~q_reg : (~q_reg + 1'b1));
    assign done = done_reg;

endmodule

FILE: sv/mlet_dp.sv
// mlet_dp: line table memories, read registers, breakpoint logic,
// divider and query multiply-add
// depends on mlet_pkg and mlet_div
module mlet_dp #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mlet_pkg::dp_cmd_t                  cmd,
    input  logic [AW-1:0]                      rd_addr,
    input  logic [AW-1:0]                      wr_addr,
    input  logic signed [mlet_pkg::SLOPE_W-1:0] slope,
    input  logic signed [mlet_pkg::ICPT_W-1:0]  intercept,
    input  logic signed [mlet_pkg::SLOPE_W-1:0] query_x,
    output mlet_pkg::dp_stat_t                 stat,
    output logic signed [mlet_pkg::VAL_W-1:0]  value
);
    import mlet_pkg::*;

    logic signed [SLOPE_W-1:0] slope_mem [CAPACITY];
    logic signed [ICPT_W-1:0]  icpt_mem  [CAPACITY];
    logic signed [VAL_W-1:0]   bp_mem    [CAPACITY];

    logic signed [SLOPE_W-1:0] rs_reg, sa_reg, sb_reg, new_s_reg, qx_reg;
    logic signed [ICPT_W-1:0]  ri_reg, ia_reg, ib_reg, new_i_reg;
    logic signed [VAL_W-1:0]   rb_reg, bb_reg, bp_reg, prod_reg, acc_reg, value_reg;

    logic signed [VAL_W-1:0]   div_num;
    logic signed [DEN_W-1:0]   div_den;
    logic        [VAL_W-1:0]   div_quo;
    logic                      div_done;

    assign div_num = VAL_W'(ri_reg) - VAL_W'(ia_reg);
    assign div_den = DEN_W'(sa_reg) - DEN_W'(rs_reg);

    mlet_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        rs_reg <= slope_mem[rd_addr];
        ri_reg <= icpt_mem[rd_addr];
        rb_reg <= bp_mem[rd_addr];
        case (cmd.wr_kind)
            WR_MOVE:
            begin
                slope_mem[wr_addr] <= rs_reg;
                icpt_mem[wr_addr]  <= ri_reg;
                bp_mem[wr_addr]    <= rb_reg;
            end
            WR_NEW:
            begin
                slope_mem[wr_addr] <= new_s_reg;
                icpt_mem[wr_addr]  <= new_i_reg;
                bp_mem[wr_addr]    <= '0;
            end
            WR_BP:   bp_mem[wr_addr] <= bp_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            new_s_reg <= slope;
            new_i_reg <= intercept;
            qx_reg    <= query_x;
            acc_reg   <= '0;
        end
        else if (cmd.acc_sum)
        begin
            acc_reg <= prod_reg + VAL_W'(ri_reg);
        end
        if (cmd.ld_a)
        begin
            sa_reg <= rs_reg;
            ia_reg <= ri_reg;
        end
        if (cmd.ld_b)
        begin
            sb_reg <= rs_reg;
            ib_reg <= ri_reg;
            bb_reg <= rb_reg;
        end
        if (cmd.bp_load)
        begin
            case (cmd.bp_src)
                BP_SENT: bp_reg <= SENTINEL;
                BP_EQ:   bp_reg <= (ia_reg >= ri_reg) ? SENTINEL : -SENTINEL;
                default: bp_reg <= div_quo;
            endcase
        end
        if (cmd.mul)
        begin
            prod_reg <= VAL_W'(rs_reg) * VAL_W'(qx_reg);
        end
        if (cmd.val_load)
        begin
            value_reg <= acc_reg;
        end
    end

    always_comb
    begin
        stat.slope_le   = rs_reg <= new_s_reg;
        stat.slope_eq   = sa_reg == rs_reg;
        stat.bp_lt_x    = rb_reg < VAL_W'(qx_reg);
        stat.covers_raw = (sa_reg == sb_reg) ? (ia_reg >= ib_reg) : (bp_reg >= bb_reg);
        stat.div_done   = div_done;
    end

    assign value = value_reg;

endmodule

FILE: sv/mlet_ctrl.sv
// mlet_ctrl: sequencer for insert, query and clear over the line table,
// with output register and status
// depends on mlet_pkg
module mlet_ctrl #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output mlet_pkg::dp_cmd_t  cmd,
    input  mlet_pkg::dp_stat_t stat,
    output logic [AW-1:0]      rd_addr,
    output logic [AW-1:0]      wr_addr
);
    import mlet_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_RESP,
        S_SRCH, S_SCMP, S_SHF, S_SHW, S_NEW,
        S_A_TOP, S_A_CHK, S_B_TOP, S_B_CHK, S_C_TOP, S_C_CHK, S_C_SB,
        S_SB1, S_SB2, S_SB3, S_SB_WR,
        S_RM, S_RM_W,
        S_Q_CHK, S_Q_ADD
    } state_t;

    state_t        state_reg, ret_reg, ret2_reg, ret3_reg;
    logic [CW-1:0] cnt_reg, k_reg, pos_reg, x_reg, bi_reg;
    logic [AW-1:0] addr_reg;
    logic          has_next_reg;
    logic [1:0]    st_reg;
    logic [1:0]    status_reg;
    logic          out_valid_reg;

    logic [CW:0]   k_p1, bi_p1;
    logic [CW-1:0] x_m1;
    logic          bi_has_next, covers, out_free, q_more;

    always_comb
    begin
        k_p1        = {1'b0, k_reg} + 1'b1;
        bi_p1       = {1'b0, bi_reg} + 1'b1;
        x_m1        = x_reg - 1'b1;
        bi_has_next = bi_p1 < {1'b0, cnt_reg};
        covers      = has_next_reg && stat.covers_raw;
        out_free    = !out_valid_reg || out_ready;
        q_more      = (k_p1 < {1'b0, cnt_reg}) && stat.bp_lt_x;
    end

    always_comb
    begin
        cmd     = '0;
        wr_addr = k_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:  cmd.ld_in = in_valid;
            S_SB1:
            begin
                cmd.ld_a = 1'b1;
                if (!bi_has_next)
                begin
                    cmd.bp_load = 1'b1;
                    cmd.bp_src  = BP_SENT;
                end
            end
            S_SB2:
            begin
                cmd.ld_b = 1'b1;
                if (stat.slope_eq)
                begin
                    cmd.bp_load = 1'b1;
                    cmd.bp_src  = BP_EQ;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            S_SB3:
            begin
                cmd.bp_load = stat.div_done;
                cmd.bp_src  = BP_DIV;
            end
            S_SB_WR:
            begin
                cmd.wr_kind = WR_BP;
                wr_addr     = bi_reg[AW-1:0];
            end
            S_SHW, S_RM_W: cmd.wr_kind = WR_MOVE;
            S_NEW:
            begin
                cmd.wr_kind = WR_NEW;
                wr_addr     = pos_reg[AW-1:0];
            end
            S_Q_CHK: cmd.mul      = !q_more;
            S_Q_ADD: cmd.acc_sum  = 1'b1;
            S_RESP:  cmd.val_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            ret2_reg      <= S_IDLE;
            ret3_reg      <= S_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            x_reg         <= '0;
            bi_reg        <= '0;
            addr_reg      <= '0;
            has_next_reg  <= 1'b0;
            st_reg        <= ST_OK;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        st_reg    <= ST_OK;
                        k_reg     <= '0;
                        state_reg <= S_RESP;
                        case (operation)
                            OP_INSERT:
                            begin
                                if (cnt_reg == CW'(CAPACITY))
                                    st_reg <= ST_FULL;
                                else
                                    state_reg <= S_SRCH;
                            end
                            OP_QUERY:
                            begin
                                if (cnt_reg == '0)
                                    st_reg <= ST_EMPTY;
                                else
                                begin
                                    addr_reg  <= '0;
                                    ret_reg   <= S_Q_CHK;
                                    state_reg <= S_RD_WAIT;
                                end
                            end
                            OP_CLEAR: cnt_reg <= '0;
                            default:  ;
                        endcase
                    end
                end
                S_RD_WAIT: state_reg <= ret_reg;
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                // find the first entry with a larger slope
                S_SRCH:
                begin
                    if (k_reg < cnt_reg)
                    begin
                        addr_reg  <= k_reg[AW-1:0];
                        ret_reg   <= S_SCMP;
                        state_reg <= S_RD_WAIT;
                    end
                    else
                    begin
                        pos_reg   <= k_reg;
                        k_reg     <= cnt_reg;
                        state_reg <= S_SHF;
                    end
                end
                S_SCMP:
                begin
                    if (stat.slope_le)
                    begin
                        k_reg     <= k_p1[CW-1:0];
                        state_reg <= S_SRCH;
                    end
                    else
                    begin
                        pos_reg   <= k_reg;
                        k_reg     <= cnt_reg;
                        state_reg <= S_SHF;
                    end
                end
                S_SHF:
                begin
                    if (k_reg > pos_reg)
                    begin
                        addr_reg  <= AW'(k_reg - 1'b1);
                        ret_reg   <= S_SHW;
                        state_reg <= S_RD_WAIT;
                    end
                    else
                        state_reg <= S_NEW;
                end
                S_SHW:
                begin
                    k_reg     <= k_reg - 1'b1;
                    state_reg <= S_SHF;
                end
                S_NEW:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    x_reg     <= pos_reg;
                    state_reg <= S_A_TOP;
                end
                // drop followers dominated by the new line
                S_A_TOP:
                begin
                    bi_reg    <= x_reg;
                    addr_reg  <= x_reg[AW-1:0];
                    ret_reg   <= S_SB1;
                    ret2_reg  <= S_A_CHK;
                    state_reg <= S_RD_WAIT;
                end
                S_A_CHK:
                begin
                    if (covers)
                    begin
                        k_reg     <= CW'(x_reg + 1'b1);
                        ret3_reg  <= S_A_TOP;
                        state_reg <= S_RM;
                    end
                    else
                        state_reg <= S_B_TOP;
                end
                S_B_TOP, S_C_TOP:
                begin
                    if (x_reg != '0)
                    begin
                        bi_reg    <= x_m1;
                        addr_reg  <= x_m1[AW-1:0];
                        ret_reg   <= S_SB1;
                        ret2_reg  <= (state_reg == S_B_TOP) ? S_B_CHK : S_C_CHK;
                        state_reg <= S_RD_WAIT;
                    end
                    else
                        state_reg <= S_RESP;
                end
                S_B_CHK:
                begin
                    if (!covers)
                        x_reg <= x_m1;
                    state_reg <= S_C_TOP;
                end
                // drop predecessors the new envelope hides
                S_C_CHK:
                begin
                    if (covers)
                    begin
                        x_reg     <= x_m1;
                        k_reg     <= x_reg;
                        ret3_reg  <= S_C_SB;
                        state_reg <= S_RM;
                    end
                    else
                        state_reg <= S_RESP;
                end
                S_C_SB:
                begin
                    bi_reg    <= x_reg;
                    addr_reg  <= x_reg[AW-1:0];
                    ret_reg   <= S_SB1;
                    ret2_reg  <= S_C_TOP;
                    state_reg <= S_RD_WAIT;
                end
                // breakpoint of entry bi against entry bi+1
                S_SB1:
                begin
                    has_next_reg <= bi_has_next;
                    if (bi_has_next)
                    begin
                        addr_reg  <= bi_p1[AW-1:0];
                        ret_reg   <= S_SB2;
                        state_reg <= S_RD_WAIT;
                    end
                    else
                        state_reg <= S_SB_WR;
                end
                S_SB2:   state_reg <= stat.slope_eq ? S_SB_WR : S_SB3;
                S_SB3:
                begin
                    if (stat.div_done)
                        state_reg <= S_SB_WR;
                end
                S_SB_WR: state_reg <= ret2_reg;
                // compact the table over entry k
                S_RM:
                begin
                    if (k_p1 < {1'b0, cnt_reg})
                    begin
                        addr_reg  <= k_p1[AW-1:0];
                        ret_reg   <= S_RM_W;
                        state_reg <= S_RD_WAIT;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= ret3_reg;
                    end
                end
                S_RM_W:
                begin
                    k_reg     <= k_p1[CW-1:0];
                    state_reg <= S_RM;
                end
                S_Q_CHK:
                begin
                    if (q_more)
                    begin
                        k_reg     <= k_p1[CW-1:0];
                        addr_reg  <= k_p1[AW-1:0];
                        ret_reg   <= S_Q_CHK;
                        state_reg <= S_RD_WAIT;
                    end
                    else
                        state_reg <= S_Q_ADD;
                end
                S_Q_ADD: state_reg <= S_RESP;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign rd_addr   = addr_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("line count above capacity");

    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NEW |=> cnt_reg == CW'($past(cnt_reg) + 1'b1))
        else $error("insert did not grow the table");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SB3 && !stat.div_done) |=> state_reg == S_SB3)
        else $error("left divide wait early");

    a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not presented");

endmodule

FILE: sv/max_line_envelope_table_top.sv
// max_line_envelope_table_top: upper envelope of lines kept sorted by slope,
// with insert, query-maximum and clear operations
// depends on mlet_pkg, mlet_ctrl, mlet_dp (and mlet_div below it)
//
// usage:
//   input channel in_valid/in_ready carries operation, slope, intercept and
//   query_x; one item is worked at a time and in_ready is high only while
//   the sequencer is idle. every item gives exactly one result transfer on
//   out_valid/out_ready with value and status.
//   clear, unused codes, refused inserts and empty queries: the sequencer goes
//   straight to the result state, which registers the result.
//   query at entry i: a registered table read and a compare per entry walked
//   up to entry i, then one 32x32 multiply and a 64-bit add.
//   insert into a table of n lines: a search for the slot and a shift of the
//   later entries, a registered read and write per entry moved during
//   compaction, and each breakpoint, dominated by the 64-step serial divider.
//   while out_ready is low a finished result holds in the result register;
//   the sequencer may take and work one more item meanwhile, then waits with
//   in_ready low until the held result is taken.
//   reset empties the table at once; no clearing pass is needed.
module max_line_envelope_table_top #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic signed [mlet_pkg::SLOPE_W-1:0] slope,
    input  logic signed [mlet_pkg::ICPT_W-1:0]  intercept,
    input  logic signed [mlet_pkg::SLOPE_W-1:0] query_x,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mlet_pkg::VAL_W-1:0]   value,
    output logic [1:0]                          status
);
    import mlet_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    mlet_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .stat      (stat),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    mlet_dp #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .slope     (slope),
        .intercept (intercept),
        .query_x   (query_x),
        .stat      (stat),
        .value     (value)
    );

endmodule

FILE: tb/max_line_envelope_table_top_tb.sv
// max_line_envelope_table_top_tb: self-checking bench for the max line envelope table
// predicts each result with its own envelope table and compares it against the block
// depends on mlet_pkg and max_line_envelope_table_top
module max_line_envelope_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlet_pkg::*;

    localparam int CAP = 64;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] sl;
        logic signed [62:0] ic;
        logic signed [31:0] qx;
    } line_op_t;

    typedef struct {
        logic signed [63:0] val;
        logic [1:0]         st;
    } answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         operation = OP_CLEAR;
    logic signed [31:0] slope = '0;
    logic signed [62:0] intercept = '0;
    logic signed [31:0] query_x = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [63:0] value;
    logic [1:0]         status;

    line_op_t pending_ops[$];
    answer_t  expected_answers[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int gen_count = 0;

    // envelope table kept by the bench
    longint env_slope[CAP];
    longint env_icpt[CAP];
    longint env_bp[CAP];
    int     env_count = 0;

    max_line_envelope_table_top #(.CAPACITY(CAP)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .slope(slope), .intercept(intercept), .query_x(query_x),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .status(status)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        longint r;
        if (d == 0)
            return 0;
        q = n / d;
        r = n % d;
        if (r != 0 && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic void drop_entry(int i);
        for (int k = i; k + 1 < env_count; k++)
        begin
            env_slope[k] = env_slope[k+1];
            env_icpt[k]  = env_icpt[k+1];
            env_bp[k]    = env_bp[k+1];
        end
        env_count--;
    endfunction

    function automatic void update_breakpoint(int i);
        int j;
        j = i + 1;
        if (j >= env_count)
            env_bp[i] = SENTINEL;
        else if (env_slope[i] == env_slope[j])
            env_bp[i] = (env_icpt[i] >= env_icpt[j]) ? SENTINEL : -SENTINEL;
        else
            env_bp[i] = floor_quot(env_icpt[j] - env_icpt[i], env_slope[i] - env_slope[j]);
    endfunction

    function automatic bit shadows_next(int i);
        int j;
        j = i + 1;
        update_breakpoint(i);
        if (j >= env_count)
            return 1'b0;
        if (env_slope[i] == env_slope[j])
            return env_icpt[i] >= env_icpt[j];
        return env_bp[i] >= env_bp[j];
    endfunction

    function automatic void add_line(longint a, longint b);
        int pos;
        int x;
        pos = 0;
        while (pos < env_count && env_slope[pos] <= a)
            pos++;
        for (int k = env_count; k > pos; k--)
        begin
            env_slope[k] = env_slope[k-1];
            env_icpt[k]  = env_icpt[k-1];
            env_bp[k]    = env_bp[k-1];
        end
        env_slope[pos] = a;
        env_icpt[pos]  = b;
        env_bp[pos]    = 0;
        env_count++;
        x = pos;
        while (shadows_next(x))
        begin
            drop_entry(x + 1);
            update_breakpoint(x);
        end
        if (x > 0 && !shadows_next(x - 1))
        begin
            x--;
            update_breakpoint(x);
        end
        while (x > 0 && shadows_next(x - 1))
        begin
            x--;
            drop_entry(x + 1);
            update_breakpoint(x);
        end
    endfunction

    function automatic answer_t envelope_answer(logic [1:0] op, logic signed [31:0] sl,
                                                logic signed [62:0] ic,
                                                logic signed [31:0] qx);
        answer_t r;
        longint xv;
        int i;
        r.val = '0;
        r.st  = ST_OK;
        if (op == OP_INSERT)
        begin
            if (env_count >= CAP)
                r.st = ST_FULL;
            else
                add_line(longint'(sl), longint'(ic));
        end
        else if (op == OP_QUERY)
        begin
            if (env_count == 0)
                r.st = ST_EMPTY;
            else
            begin
                xv = longint'(qx);
                i = 0;
                while (i + 1 < env_count && env_bp[i] < xv)
                    i++;
                r.val = env_slope[i] * xv + env_icpt[i];
            end
        end
        else if (op == OP_CLEAR)
            env_count = 0;
        return r;
    endfunction

    // input side: present queued items, hold them until the transfer happens
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                expected_answers.push_back(envelope_answer(operation, slope, intercept, query_x));
            if (!(in_valid && !in_ready))
            begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    line_op_t it;
                    it = pending_ops.pop_front();
                    operation <= it.op;
                    slope     <= it.sl;
                    intercept <= it.ic;
                    query_x   <= it.qx;
                    in_valid  <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side: random stalls and in-order comparison
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: value=%0d status=%0d", value, status);
                end
                else
                begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (e.val !== value || e.st !== status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected value=%0d status=%0d, ",
                                      "got value=%0d status=%0d"},
                                     e.val, e.st, value, status);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on outstanding work with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("max_line_envelope_table_top test failed");
            $finish;
        end
    end

    task automatic push_op(logic [1:0] op, logic signed [31:0] sl, logic signed [62:0] ic,
                           logic signed [31:0] qx);
        line_op_t it;
        it.op = op;
        it.sl = sl;
        it.ic = ic;
        it.qx = qx;
        pending_ops.push_back(it);
        gen_count++;
    endtask

    function automatic logic signed [31:0] pick_x();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(4000)) - 2000;
            2: return $signed($urandom_range(400000)) - 200000;
            default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    // tangents of a parabola: every line stays on the envelope
    task automatic push_hull(int n);
        int base;
        int scale;
        longint offs;
        int ks[$];
        int idx;
        base  = $signed($urandom_range(2000)) - 1000;
        scale = $urandom_range(1000) + 1;
        offs  = $signed($urandom_range(2000000)) - 1000000;
        for (int k = 0; k < n; k++)
            ks.push_back(k);
        ks.shuffle();
        push_op(OP_CLEAR, $urandom, {$urandom, $urandom}, $urandom);
        foreach (ks[k])
        begin
            longint a;
            a = base + ks[k];
            push_op(OP_INSERT, a, -(a * a * scale) + offs, $urandom);
            if ($urandom_range(7) == 0)
                push_op(OP_QUERY, $urandom, {$urandom, $urandom}, pick_x());
        end
        for (int q = $urandom_range(12) + 2; q > 0; q--)
            push_op(OP_QUERY, $urandom, {$urandom, $urandom}, pick_x());
    endtask

    task automatic push_small_lines(int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(2) == 0)
                push_op(OP_QUERY, $urandom, {$urandom, $urandom}, pick_x());
            else
                push_op(OP_INSERT, $signed($urandom_range(40)) - 20,
                        $signed($urandom_range(2000)) - 1000, $urandom);
        end
    endtask

    task automatic push_noise(int n);
        for (int k = 0; k < n; k++)
            push_op($urandom_range(3), $urandom, {$urandom, $urandom}, $urandom);
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        int modes_in[4] = '{0, 79, 0, 13};
        int modes_out[4] = '{0, 0, 79, 13};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, unused code, extremes, equal slopes
        push_op(OP_QUERY, 0, 0, 0);
        push_op(OP_SPARE, 32'sh7fffffff, {63{1'b1}}, 32'sh7fffffff);
        push_op(OP_INSERT, 32'sh7fffffff, 63'sh3fffffffffffffff, 0);
        push_op(OP_INSERT, 32'sh80000000, 63'sh4000000000000000, 0);
        push_op(OP_QUERY, 0, 0, 32'sh7fffffff);
        push_op(OP_QUERY, 0, 0, 32'sh80000000);
        push_op(OP_QUERY, 0, 0, 0);
        push_op(OP_INSERT, 5, 100, 0);
        push_op(OP_INSERT, 5, 200, 0);
        push_op(OP_INSERT, 5, 50, 0);
        push_op(OP_QUERY, 0, 0, 0);
        push_op(OP_CLEAR, 0, 0, 0);
        push_op(OP_QUERY, 0, 0, 7);
        push_op(OP_INSERT, -3, 10, 0);
        push_op(OP_INSERT, -3, 10, 0);
        push_op(OP_INSERT, 2, -7, 0);
        push_op(OP_QUERY, 0, 0, 3);
        push_op(OP_QUERY, 0, 0, -3);
        // fill past capacity so the last inserts are refused
        push_hull(67);
        drain();

        gen_count = 0;
        for (int m = 0; m < 4; m++)
        begin
            idle_pct  = modes_in[m];
            stall_pct = modes_out[m];
            while (gen_count < 300 * (m + 1))
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: push_hull($urandom_range(5) == 0 ? 66 : $urandom_range(20) + 1);
                    4, 5, 6: push_small_lines($urandom_range(20) + 5);
                    default: push_noise($urandom_range(10) + 1);
                endcase
                if ($urandom_range(5) == 0)
                    drain();
            end
            // sender holds off until every result is back
            drain();
        end
        idle_pct = 0;
        stall_pct = 0;
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("max_line_envelope_table_top test passed");
        else
            $display("max_line_envelope_table_top test failed");
        $finish;
    end
endmodule
